>>> design/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high.
`define RPN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define RPN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/rpn_pkg.sv
// Shared types, constants and helpers of the RPN stack evaluator.
// No dependencies; every design module imports this package.
`timescale 1ns / 1ps

package rpn_pkg;

   localparam int STACK_DEPTH_DEF = 128;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int DATA_W          = 32;
   localparam int FUNC_W          = 3;
   localparam int STATUS_W        = 3;
   localparam int ITER_STEPS      = 32;
   localparam int CNT_W           = $clog2(ITER_STEPS);

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH    = 3'd0,
      FN_ADD     = 3'd1,
      FN_SUB     = 3'd2,
      FN_MUL     = 3'd3,
      FN_DIV     = 3'd4,
      FN_REM     = 3'd5,
      FN_PRINT   = 3'd6,
      FN_UNKNOWN = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_ZERO    = 3'd3,
      ST_UNKNOWN = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      UOP_ADD,
      UOP_SUB,
      UOP_MUL,
      UOP_DIV
   } unit_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_B,
      S_GET_B,
      S_POP_A,
      S_GET_A,
      S_RUN,
      S_PUSH,
      S_DONE
   } seq_state_type;

   // Magnitude plus sign to saturated 32-bit two's complement.
   function automatic logic [DATA_W-1:0] sat_mag(input logic [63:0] mag, input logic neg);
      logic [DATA_W-1:0] res;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) res = 32'h8000_0000;
         else                               res = ~mag[DATA_W-1:0] + 32'd1;
      end else begin
         if (mag > 64'h0000_0000_7FFF_FFFF) res = 32'h7FFF_FFFF;
         else                               res = mag[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> design/rpn_stack_mem.sv
// Operand stack storage: one write port, one read port, registered read.
// Depends on rpn_pkg for the data width.
`timescale 1ns / 1ps

module rpn_stack_mem #(
   parameter int DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [rpn_pkg::DATA_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [rpn_pkg::DATA_W-1:0]  rd_data
);
   import rpn_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rpn_iter_unit.sv
// Shared iterative arithmetic unit: one 34-bit adder reused for add/sub,
// shift-add multiply and restoring divide. Depends on rpn_pkg.
`timescale 1ns / 1ps

module rpn_iter_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  rpn_pkg::unit_op_type         op,
   input  logic [63:0]                  x_val,
   input  logic [rpn_pkg::DATA_W-1:0]   y_val,
   output logic                         done,
   output logic [rpn_pkg::DATA_W-1:0]   res_hi,
   output logic [rpn_pkg::DATA_W-1:0]   res_lo,
   output logic                         ovf
);
   import rpn_pkg::*;

   unit_op_type       op_ff, op_in;
   logic [DATA_W-1:0] hi_ff, hi_in;
   logic [DATA_W-1:0] lo_ff, lo_in;
   logic [DATA_W-1:0] arg_ff, arg_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [33:0] add_a, add_b, sum;
   logic        add_sub;

   // the one adder
   always_comb begin
      unique case (op_ff)
         UOP_ADD, UOP_SUB: begin
            add_a   = {{2{hi_ff[DATA_W-1]}}, hi_ff};
            add_b   = {{2{arg_ff[DATA_W-1]}}, arg_ff};
            add_sub = (op_ff == UOP_SUB);
         end
         UOP_MUL: begin
            add_a   = {2'b00, hi_ff};
            add_b   = lo_ff[0] ? {2'b00, arg_ff} : 34'd0;
            add_sub = 1'b0;
         end
         UOP_DIV: begin
            add_a   = {1'b0, hi_ff, lo_ff[DATA_W-1]};
            add_b   = {2'b00, arg_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_a   = '0;
            add_b   = '0;
            add_sub = 1'b0;
         end
      endcase
      sum = add_a + (add_sub ? ~add_b : add_b) + {33'd0, add_sub};
   end

   always_comb begin
      op_in   = op_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      arg_in  = arg_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         op_in   = op;
         busy_in = 1'b1;
         ovf_in  = 1'b0;
         cnt_in  = CNT_W'(ITER_STEPS - 1);
         unique case (op)
            UOP_ADD, UOP_SUB: begin
               hi_in  = x_val[DATA_W-1:0];
               lo_in  = '0;
               arg_in = y_val;
               cnt_in = '0;
            end
            UOP_MUL: begin
               hi_in  = '0;
               lo_in  = y_val;
               arg_in = x_val[DATA_W-1:0];
            end
            UOP_DIV: begin
               hi_in  = x_val[63:32];
               lo_in  = x_val[31:0];
               arg_in = y_val;
               // quotient would not fit 32 bits
               ovf_in = (x_val[63:32] >= y_val);
            end
            default: begin
               hi_in = '0;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            UOP_ADD, UOP_SUB: begin
               hi_in = {DATA_W{sum[32]}};
               lo_in = sum[31:0];
            end
            UOP_MUL: begin
               hi_in = sum[32:1];
               lo_in = {sum[0], lo_ff[DATA_W-1:1]};
            end
            UOP_DIV: begin
               hi_in = sum[33] ? {hi_ff[DATA_W-2:0], lo_ff[DATA_W-1]} : sum[31:0];
               lo_in = {lo_ff[DATA_W-2:0], ~sum[33]};
            end
            default: begin
               hi_in = hi_ff;
            end
         endcase
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      arg_ff <= arg_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign res_hi = hi_ff;
   assign res_lo = lo_ff;
   assign ovf    = ovf_ff;

endmodule

>>> design/rpn_stack_evaluator_unit.sv
// RPN stack evaluator, top level: sequencer, stack pointer, result register.
// Uses rpn_pkg, rpn_stack_mem and rpn_iter_unit.
`timescale 1ns / 1ps

// Reverse Polish evaluator on a stack of STACK_DEPTH signed Q(32-FRAC_BITS).FRAC_BITS
// values. Each request carries a command in req_tuser and, for push, a value in
// req_tdata; each request yields exactly one response with the printed value (zero
// unless the command is print) and a status code. Binary operators pop the right
// operand first, arithmetic saturates to 32 bits, popping an empty stack reads 0
// and reports stack empty, a zero divisor pops only the divisor. The block works
// on one request at a time and drops req_tready until the response is registered.
// Multiply, divide and remainder run longest, set by 32 passes through the
// shared 34-bit adder of the iterative unit (one product or quotient bit a pass);
// each stack read also waits on the registered read port of the stack memory.
// The stack memory needs no clearing after reset: entries are read only below
// the stack pointer. A response waiting on rsp_tready holds in its register.

module rpn_stack_evaluator_unit #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rpn_pkg::DATA_W-1:0]    req_tdata,   // [31:0] operand_value
   input  logic [rpn_pkg::FUNC_W-1:0]    req_tuser,   // [2:0] func
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rpn_pkg::DATA_W-1:0]    rsp_tdata,   // [31:0] top_value
   output logic [rpn_pkg::STATUS_W-1:0]  rsp_tuser    // [2:0] status
);
   import rpn_pkg::*;

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int AW   = $clog2(STACK_DEPTH);

   seq_state_type     state_ff, state_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   func_type          func_ff, func_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic              neg_ff, neg_in;
   logic              got_ff, got_in;      // pop really read the stack
   logic              empty_ff, empty_in;
   status_type        stat_ff, stat_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type        rsp_user_ff, rsp_user_in;

   // stack memory port
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata, mem_rdata;

   // iterative unit port
   logic              u_start, u_done, u_ovf;
   unit_op_type       u_op;
   logic [63:0]       u_x;
   logic [DATA_W-1:0] u_y, u_hi, u_lo;

   logic [SP_W-1:0]   sp_dec;
   logic [DATA_W-1:0] rd_val, mag_a, mag_b, mag_rd, result;
   logic              accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign sp_dec     = sp_ff - SP_W'(1);
   assign rd_val     = got_ff ? mem_rdata : '0;
   assign mag_rd     = rd_val[DATA_W-1] ? (~rd_val + 32'd1) : rd_val;
   assign mag_a      = mag_rd;
   assign mag_b      = b_ff[DATA_W-1] ? (~b_ff + 32'd1) : b_ff;

   // saturated value to push back after the unit is done
   always_comb begin
      unique case (func_ff)
         FN_ADD, FN_SUB: begin
            if (u_hi[0] != u_lo[DATA_W-1]) result = u_hi[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else                           result = u_lo;
         end
         FN_MUL:  result = sat_mag({u_hi, u_lo} >> FRAC_BITS, neg_ff);
         FN_DIV:  result = sat_mag(u_ovf ? {64{1'b1}} : {32'd0, u_lo}, neg_ff);
         FN_REM:  result = sat_mag({32'd0, u_hi} << FRAC_BITS, neg_ff);
         default: result = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      func_in      = func_ff;
      b_in         = b_ff;
      neg_in       = neg_ff;
      got_in       = got_ff;
      empty_in     = empty_ff;
      stat_in      = stat_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_waddr    = sp_ff[AW-1:0];
      mem_wdata    = req_tdata;
      mem_raddr    = sp_dec[AW-1:0];
      u_start      = 1'b0;
      u_op         = UOP_ADD;
      u_x          = '0;
      u_y          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in  = func_type'(req_tuser);
               empty_in = 1'b0;
               stat_in  = ST_OK;
               top_in   = '0;
               unique case (func_type'(req_tuser))
                  FN_PUSH: begin
                     if (sp_ff == SP_W'(STACK_DEPTH)) begin
                        stat_in = ST_FULL;
                     end else begin
                        mem_we = 1'b1;
                        sp_in  = sp_ff + SP_W'(1);
                     end
                     state_in = S_DONE;
                  end
                  FN_UNKNOWN: begin
                     stat_in  = ST_UNKNOWN;
                     state_in = S_DONE;
                  end
                  default: state_in = S_POP_B;
               endcase
            end
         end
         S_POP_B, S_POP_A: begin
            got_in = (sp_ff != '0);
            if (sp_ff != '0) sp_in = sp_dec;
            else             empty_in = 1'b1;
            state_in = (state_ff == S_POP_B) ? S_GET_B : S_GET_A;
         end
         S_GET_B: begin
            b_in     = rd_val;
            state_in = S_POP_A;
            unique case (func_ff)
               FN_PRINT: begin
                  top_in   = rd_val;
                  state_in = S_DONE;
               end
               FN_DIV: begin
                  if (rd_val == '0) begin
                     stat_in  = ST_ZERO;
                     state_in = S_DONE;
                  end
               end
               FN_REM: begin
                  // integer part of the divisor is zero
                  if ((mag_rd >> FRAC_BITS) == '0) begin
                     stat_in  = ST_ZERO;
                     state_in = S_DONE;
                  end
               end
               default: state_in = S_POP_A;
            endcase
         end
         S_GET_A: begin
            u_start  = 1'b1;
            state_in = S_RUN;
            neg_in   = rd_val[DATA_W-1] ^ b_ff[DATA_W-1];
            unique case (func_ff)
               FN_SUB: begin
                  u_op = UOP_SUB;
                  u_x  = {32'd0, rd_val};
                  u_y  = b_ff;
               end
               FN_MUL: begin
                  u_op = UOP_MUL;
                  u_x  = {32'd0, mag_a};
                  u_y  = mag_b;
               end
               FN_DIV: begin
                  u_op = UOP_DIV;
                  u_x  = {32'd0, mag_a} << FRAC_BITS;
                  u_y  = mag_b;
               end
               FN_REM: begin
                  u_op   = UOP_DIV;
                  u_x    = {32'd0, mag_a >> FRAC_BITS};
                  u_y    = mag_b >> FRAC_BITS;
                  neg_in = rd_val[DATA_W-1];
               end
               default: begin
                  u_op = UOP_ADD;
                  u_x  = {32'd0, rd_val};
                  u_y  = b_ff;
               end
            endcase
         end
         S_RUN: begin
            if (u_done) state_in = S_PUSH;
         end
         S_PUSH: begin
            // two pops came first, so there is room
            mem_we    = 1'b1;
            mem_wdata = result;
            sp_in     = sp_ff + SP_W'(1);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = top_ff;
               rsp_user_in  = empty_ff ? ST_EMPTY : stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      b_ff        <= b_in;
      neg_ff      <= neg_in;
      got_ff      <= got_in;
      empty_ff    <= empty_in;
      stat_ff     <= stat_in;
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   rpn_stack_mem #(
      .DEPTH (STACK_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rpn_iter_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .start  (u_start),
      .op     (u_op),
      .x_val  (u_x),
      .y_val  (u_y),
      .done   (u_done),
      .res_hi (u_hi),
      .res_lo (u_lo),
      .ovf    (u_ovf)
   );

endmodule

>>> design/rpn_checker.sv
// Port-level checks of the RPN stack evaluator, bound to the top level.
// Depends on rpn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpn_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [rpn_pkg::DATA_W-1:0]    rsp_tdata,
   input logic [rpn_pkg::STATUS_W-1:0]  rsp_tuser
);
   import rpn_pkg::*;

   logic                       req_accept;
   logic                       rsp_stall;
   logic                       rsp_error;
   logic [DATA_W+STATUS_W:0]   rsp_word;    // valid, status, value

   assign req_accept = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_word   = {rsp_tvalid, rsp_tuser, rsp_tdata};
   // any status but ok is an error code
   assign rsp_error  = rsp_tvalid && (rsp_tuser != ST_OK);

   // no response pending right after reset
   `RPN_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "response valid after reset")

   // one request at a time
   `RPN_ASSERT(a_one_at_a_time, clock, reset, req_accept |=> !req_tready, "ready after accept")

   // stalled response holds
   `RPN_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> $stable(rsp_word), "stall not held")

   // any error response carries a zero value
   `RPN_ASSERT(a_err_zero, clock, reset, rsp_error |-> rsp_tdata == '0, "error value not zero")

endmodule

bind rpn_stack_evaluator_unit rpn_checker u_rpn_checker (.*);
